// ----- design/bcms_pkg.sv -----
package bcms_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TOTAL_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOTOR_SPEED      = 3'd0,
    REG_RUN_TIME_MS      = 3'd1,
    REG_DEBOUNCE_MS      = 3'd2,
    REG_RAMP_START       = 3'd3,
    REG_RAMP_STEP        = 3'd4,
    REG_RAMP_INTERVAL_MS = 3'd5,
    REG_TARGET_MAX       = 3'd6,
    REG_FLASH_MS         = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    KEY_NONE    = 2'd0,
    KEY_ADD     = 2'd1,
    KEY_CONFIRM = 2'd2,
    KEY_RESET   = 2'd3
  } key_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_MOTOR = 2'd2,
    MODE_DONE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_COUNT = 4'b0010,
    ST_MOTOR = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  localparam logic [6:0]  RST_MOTOR_SPEED      = 7'd35;
  localparam logic [15:0] RST_RUN_TIME_MS      = 16'd3000;
  localparam logic [15:0] RST_DEBOUNCE_MS      = 16'd120;
  localparam logic [6:0]  RST_RAMP_START       = 7'd25;
  localparam logic [6:0]  RST_RAMP_STEP        = 7'd5;
  localparam logic [15:0] RST_RAMP_INTERVAL_MS = 16'd100;
  localparam logic [6:0]  RST_TARGET_MAX       = 7'd99;
  localparam logic [15:0] RST_FLASH_MS         = 16'd50;

  typedef struct packed {
    logic [6:0]  motor_speed;
    logic [15:0] run_time_ms;
    logic [15:0] debounce_ms;
    logic [6:0]  ramp_start;
    logic [6:0]  ramp_step;
    logic [15:0] ramp_interval_ms;
    logic [6:0]  target_max;
    logic [15:0] flash_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [6:0]         target_value;
    logic [6:0]         count_value;
    logic [TOTAL_W-1:0] total_value;
    logic [6:0]         motor_duty;
    logic               count_led;
    logic               run_led;
  } result_t;

  function automatic logic [1:0] mode_of(state_t s);
    logic [1:0] m;
    unique case (s)
      ST_IDLE:  m = MODE_IDLE;
      ST_COUNT: m = MODE_COUNT;
      ST_MOTOR: m = MODE_MOTOR;
      ST_DONE:  m = MODE_DONE;
      default:  m = MODE_IDLE;
    endcase
    return m;
  endfunction

endpackage

// ----- design/bcms_if.sv -----
interface bcms_in_if #(
  parameter int TIME_WIDTH   = 32,
  parameter int SENSOR_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [TIME_WIDTH-1:0]   now_ms;
  logic [1:0]              action;
  logic [SENSOR_WIDTH-1:0] sensor_count;
  logic                    remote_reset;

  modport source (output valid, now_ms, action, sensor_count, remote_reset, input ready);
  modport sink   (input valid, now_ms, action, sensor_count, remote_reset, output ready);
endinterface

interface bcms_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [6:0]  target_value;
  logic [6:0]  count_value;
  logic [31:0] total_value;
  logic [6:0]  motor_duty;
  logic        count_led;
  logic        run_led;

  modport source (output valid, mode, target_value, count_value, total_value, motor_duty,
                  count_led, run_led, input ready);
  modport sink   (input valid, mode, target_value, count_value, total_value, motor_duty,
                  count_led, run_led, output ready);
endinterface

// ----- design/batch_counter_motor_sequencer_top.sv -----
// Batch counter and motor sequencer. Takes one poll word per cycle while the output is
// not stalled and returns one result word per poll, in order: the poll is first held in
// the input register, then the state update and result register are written together,
// so the throughput is one poll per clock, held back only when the output is not ready.
// Configuration writes take effect on the next clock and are meant for idle periods.
module batch_counter_motor_sequencer_top #(
  parameter int TIME_WIDTH   = 32,
  parameter int SENSOR_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [bcms_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bcms_pkg::CFG_W-1:0]     cfg_wdata,
  bcms_in_if.sink                        in_ch,
  bcms_out_if.source                     out_ch
);
  import bcms_pkg::*;

  cfg_t                    cfg;
  result_t                 res;
  result_t                 res_r;
  logic                    in_v;
  logic                    out_v;
  logic                    fire;
  logic [TIME_WIDTH-1:0]   now_r;
  logic [1:0]              action_r;
  logic [SENSOR_WIDTH-1:0] sensor_r;
  logic                    remote_r;

  assign fire        = in_v && (!out_v || out_ch.ready);
  assign in_ch.ready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_ch.ready) begin
      in_v <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      now_r    <= in_ch.now_ms;
      action_r <= in_ch.action;
      sensor_r <= in_ch.sensor_count;
      remote_r <= in_ch.remote_reset;
    end
  end

  bcms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bcms_seq #(
    .TIME_WIDTH   (TIME_WIDTH),
    .SENSOR_WIDTH (SENSOR_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .cfg          (cfg),
    .now_ms       (now_r),
    .action       (action_r),
    .sensor_count (sensor_r),
    .remote_reset (remote_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (fire) begin
      out_v <= 1'b1;
    end else if (out_ch.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_v;
  assign out_ch.mode         = res_r.mode;
  assign out_ch.target_value = res_r.target_value;
  assign out_ch.count_value  = res_r.count_value;
  assign out_ch.total_value  = res_r.total_value;
  assign out_ch.motor_duty   = res_r.motor_duty;
  assign out_ch.count_led    = res_r.count_led;
  assign out_ch.run_led      = res_r.run_led;

`ifndef SYNTHESIS
  a_run_led_motor: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_ch.run_led == (out_ch.mode == MODE_MOTOR)))
    else $error("run led out of step with motor state");

  a_duty_only_motor: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_ch.mode != MODE_MOTOR) |-> (out_ch.motor_duty == '0))
    else $error("motor duty nonzero outside motor run");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_ch.mode == MODE_IDLE) |-> (out_ch.count_value == '0))
    else $error("count nonzero in idle");

  a_result_follows_fire: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_v)
    else $error("processed word lost before output register");
`endif

endmodule

// ----- design/bcms_cfg.sv -----
module bcms_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [bcms_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [bcms_pkg::CFG_W-1:0]          cfg_wdata,
  output bcms_pkg::cfg_t                      cfg
);
  import bcms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motor_speed      <= RST_MOTOR_SPEED;
      cfg.run_time_ms      <= RST_RUN_TIME_MS;
      cfg.debounce_ms      <= RST_DEBOUNCE_MS;
      cfg.ramp_start       <= RST_RAMP_START;
      cfg.ramp_step        <= RST_RAMP_STEP;
      cfg.ramp_interval_ms <= RST_RAMP_INTERVAL_MS;
      cfg.target_max       <= RST_TARGET_MAX;
      cfg.flash_ms         <= RST_FLASH_MS;
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MOTOR_SPEED:      cfg.motor_speed      <= cfg_wdata[6:0];
        REG_RUN_TIME_MS:      cfg.run_time_ms      <= cfg_wdata;
        REG_DEBOUNCE_MS:      cfg.debounce_ms      <= cfg_wdata;
        REG_RAMP_START:       cfg.ramp_start       <= cfg_wdata[6:0];
        REG_RAMP_STEP:        cfg.ramp_step        <= cfg_wdata[6:0];
        REG_RAMP_INTERVAL_MS: cfg.ramp_interval_ms <= cfg_wdata;
        REG_TARGET_MAX:       cfg.target_max       <= cfg_wdata[6:0];
        REG_FLASH_MS:         cfg.flash_ms         <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/bcms_seq.sv -----
module bcms_seq #(
  parameter int TIME_WIDTH   = 32,
  parameter int SENSOR_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  bcms_pkg::cfg_t          cfg,
  input  logic [TIME_WIDTH-1:0]   now_ms,
  input  logic [1:0]              action,
  input  logic [SENSOR_WIDTH-1:0] sensor_count,
  input  logic                    remote_reset,
  output bcms_pkg::result_t       res
);
  import bcms_pkg::*;

  state_t                  state, state_next;
  logic [6:0]              target_reg, target_reg_next;
  logic [6:0]              count_reg, count_reg_next;
  logic [TOTAL_W-1:0]      total_reg, total_reg_next;
  logic [SENSOR_WIDTH-1:0] last_sensor, last_sensor_next;
  logic [TIME_WIDTH-1:0]   last_accept_ms, last_accept_ms_next;
  logic [TIME_WIDTH-1:0]   run_start_ms, run_start_ms_next;
  logic [7:0]              ramp_duty, ramp_duty_next;
  logic [TIME_WIDTH-1:0]   ramp_mark_ms, ramp_mark_ms_next;
  logic                    ramp_finished, ramp_finished_next;
  logic                    flash_on, flash_on_next;
  logic [TIME_WIDTH-1:0]   flash_start_ms, flash_start_ms_next;
  logic                    run_lamp, run_lamp_next;

  state_t     cur;
  logic       stop_key;
  logic       drop;
  logic [7:0] tgt_inc;
  logic [6:0] cnt_inc;
  logic [7:0] duty_sum;
  logic [7:0] speed8;
  logic [6:0] start_clamp;

  function automatic logic due(logic [TIME_WIDTH-1:0] now, logic [TIME_WIDTH-1:0] then,
                               logic [15:0] lim);
    logic [TIME_WIDTH-1:0] d;
    d = now - then;
    return d >= TIME_WIDTH'(lim);
  endfunction

  assign stop_key    = (key_t'(action) == KEY_CONFIRM) || (key_t'(action) == KEY_RESET);
  assign speed8      = {1'b0, cfg.motor_speed};
  assign start_clamp = (cfg.ramp_start > cfg.motor_speed) ? cfg.motor_speed : cfg.ramp_start;
  assign tgt_inc     = {1'b0, target_reg} + 8'd1;
  assign cnt_inc     = count_reg + 7'd1;
  assign duty_sum    = ramp_duty + {1'b0, cfg.ramp_step};
  assign cur         = remote_reset ? ST_IDLE : state;

  always_comb begin
    state_next          = state;
    target_reg_next     = target_reg;
    count_reg_next      = count_reg;
    total_reg_next      = total_reg;
    last_sensor_next    = last_sensor;
    last_accept_ms_next = last_accept_ms;
    run_start_ms_next   = run_start_ms;
    ramp_duty_next      = ramp_duty;
    ramp_mark_ms_next   = ramp_mark_ms;
    ramp_finished_next  = ramp_finished;
    flash_on_next       = flash_on;
    flash_start_ms_next = flash_start_ms;
    run_lamp_next       = run_lamp;
    drop                = 1'b0;

    if (flash_on && due(now_ms, flash_start_ms, cfg.flash_ms)) begin
      flash_on_next = 1'b0;
    end

    if (remote_reset) begin
      ramp_duty_next     = '0;
      ramp_finished_next = 1'b0;
      run_lamp_next      = 1'b0;
      target_reg_next    = '0;
      count_reg_next     = '0;
      state_next         = ST_IDLE;
    end

    unique case (cur)
      ST_IDLE: begin
        unique case (key_t'(action))
          KEY_ADD: begin
            target_reg_next = (tgt_inc > {1'b0, cfg.target_max}) ? 7'd0 : tgt_inc[6:0];
            if (remote_reset) begin
              target_reg_next = 7'd1 > cfg.target_max ? 7'd0 : 7'd1;
            end
          end
          KEY_CONFIRM: begin
            if (target_reg_next != '0) begin
              count_reg_next      = '0;
              last_sensor_next    = sensor_count;
              last_accept_ms_next = now_ms;
              state_next          = ST_COUNT;
            end
          end
          KEY_RESET: begin
            target_reg_next = '0;
            count_reg_next  = '0;
          end
          KEY_NONE: ;
          default: ;
        endcase
      end
      ST_COUNT: begin
        if (stop_key) begin
          drop = 1'b1;
        end else begin
          last_sensor_next = sensor_count;
          if (sensor_count != last_sensor && due(now_ms, last_accept_ms, cfg.debounce_ms)) begin
            count_reg_next      = cnt_inc;
            last_accept_ms_next = now_ms;
            flash_on_next       = 1'b1;
            flash_start_ms_next = now_ms;
            if (cnt_inc >= target_reg) begin
              total_reg_next      = total_reg + TOTAL_W'(cnt_inc);
              run_start_ms_next   = now_ms;
              ramp_duty_next      = {1'b0, start_clamp};
              ramp_mark_ms_next   = now_ms;
              ramp_finished_next  = (start_clamp >= cfg.motor_speed);
              run_lamp_next       = 1'b1;
              state_next          = ST_MOTOR;
            end
          end
        end
      end
      ST_MOTOR: begin
        if (stop_key) begin
          drop = 1'b1;
        end else begin
          if (!ramp_finished && due(now_ms, ramp_mark_ms, cfg.ramp_interval_ms)) begin
            if (duty_sum >= speed8) begin
              ramp_duty_next     = speed8;
              ramp_finished_next = 1'b1;
            end else begin
              ramp_duty_next = duty_sum;
            end
            ramp_mark_ms_next = now_ms;
          end
          if (due(now_ms, run_start_ms, cfg.run_time_ms)) begin
            ramp_duty_next     = '0;
            ramp_finished_next = 1'b0;
            run_lamp_next      = 1'b0;
            state_next         = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        drop = stop_key;
      end
      default: begin
        drop = 1'b1;
      end
    endcase

    if (drop) begin
      ramp_duty_next     = '0;
      ramp_finished_next = 1'b0;
      run_lamp_next      = 1'b0;
      target_reg_next    = '0;
      count_reg_next     = '0;
      state_next         = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      target_reg     <= '0;
      count_reg      <= '0;
      total_reg      <= '0;
      last_sensor    <= '0;
      last_accept_ms <= '0;
      run_start_ms   <= '0;
      ramp_duty      <= '0;
      ramp_mark_ms   <= '0;
      ramp_finished  <= 1'b0;
      flash_on       <= 1'b0;
      flash_start_ms <= '0;
      run_lamp       <= 1'b0;
    end else if (fire) begin
      state          <= state_next;
      target_reg     <= target_reg_next;
      count_reg      <= count_reg_next;
      total_reg      <= total_reg_next;
      last_sensor    <= last_sensor_next;
      last_accept_ms <= last_accept_ms_next;
      run_start_ms   <= run_start_ms_next;
      ramp_duty      <= ramp_duty_next;
      ramp_mark_ms   <= ramp_mark_ms_next;
      ramp_finished  <= ramp_finished_next;
      flash_on       <= flash_on_next;
      flash_start_ms <= flash_start_ms_next;
      run_lamp       <= run_lamp_next;
    end
  end

  always_comb begin
    res.mode         = mode_of(state_next);
    res.target_value = target_reg_next;
    res.count_value  = count_reg_next;
    res.total_value  = total_reg_next;
    res.motor_duty   = ramp_duty_next[6:0];
    res.count_led    = flash_on_next;
    res.run_led      = run_lamp_next;
  end

endmodule
